/* sv/sorted_timer_event_queue_defines.svh */
// Assertion macros shared by the timer queue RTL.
`ifndef SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define STEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked while out of reset.
`define STEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STEQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define STEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/steq_pkg.sv */
`default_nettype none
package steq_pkg;
    localparam int DL_W  = 48;
    localparam int KEY_W = 32;
    localparam int TAG_W = 8;
    localparam int DLY_W = 32;
    localparam int RES_W = 20;
    localparam logic [RES_W-1:0] RES_RESET = 20'd1000;

    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] handler;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CHK, S_INS_SHIFT, S_INS_MOVE,
        S_REM_RD, S_REM_CHK, S_REM_SHIFT, S_REM_MOVE,
        S_FIRE_RD, S_FIRE_CHK, S_STATUS
    } t_state;
endpackage
`default_nettype wire

/* sv/steq_ram.sv */
`default_nettype none
module steq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/sorted_timer_event_queue.sv */
// Each item is handled alone: the search walks the table entries, the insert or remove
// shift moves entries, due events fire from the head, and a status word ends the item.
// New items are taken only in idle, one item at a time; output stalls hold the walk.
// Reset clears the entry count, head pointer and output valid, and loads the
// resolution with 1000; table contents stay undefined and no clearing pass runs.
`default_nettype none
`include "sorted_timer_event_queue_defines.svh"
module sorted_timer_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [steq_pkg::RES_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_kind,
    input  wire logic [steq_pkg::DL_W-1:0] i_now_time,
    input  wire logic [steq_pkg::DLY_W-1:0] i_delay,
    input  wire logic [steq_pkg::KEY_W-1:0] i_key,
    input  wire logic [steq_pkg::TAG_W-1:0] i_handler_tag,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_is_status,
    output logic [steq_pkg::KEY_W-1:0]     o_fired_key,
    output logic [steq_pkg::TAG_W-1:0]     o_fired_handler,
    output logic [1:0]                     o_status,
    output logic                           o_queue_empty,
    output logic [steq_pkg::DL_W-1:0]      o_next_deadline,
    output logic                           o_last
);
    import steq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(QUEUE_DEPTH);

    t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count, r_idx, n_idx, r_pos, n_pos, r_j, n_j;
    logic [AW-1:0]   r_head, n_head;
    logic [RES_W-1:0] r_res;
    logic [DL_W-1:0] r_dl, r_head_dl, n_head_dl;
    logic [DL_W:0]   r_limit;
    logic [KEY_W-1:0] r_key;
    logic [TAG_W-1:0] r_tag;
    logic [1:0]      r_status, n_status;

    logic            r_out_valid, n_out_valid;
    logic            r_is_status, n_is_status, r_last, n_last, r_empty, n_empty;
    logic [KEY_W-1:0] r_okey, n_okey;
    logic [TAG_W-1:0] r_otag, n_otag;
    logic [1:0]      r_ostat, n_ostat;
    logic [DL_W-1:0] r_odl, n_odl;

    logic            ram_we, ram_re, out_free, accept;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    t_slot           ram_wdata, ram_rdata;
    logic [DL_W:0]   add_sum, lim_sum;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx[AW-1:0]};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    steq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign add_sum     = {1'b0, i_now_time} + {17'b0, i_delay};
    assign lim_sum     = {1'b0, i_now_time} + {29'b0, r_res};

    // Sequence search, shift and fire steps over the table RAM
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx = r_idx;
        n_pos = r_pos;
        n_j = r_j;
        n_head = r_head;
        n_head_dl = r_head_dl;
        n_status = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_is_status = r_is_status;
        n_last = r_last;
        n_empty = r_empty;
        n_okey = r_okey;
        n_otag = r_otag;
        n_ostat = r_ostat;
        n_odl = r_odl;
        ram_we = 1'b0;
        ram_waddr = f_phys(r_head, r_j);
        ram_wdata = ram_rdata;
        ram_re = 1'b0;
        ram_raddr = f_phys(r_head, r_idx);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_status = ST_OK;
                    if (i_kind == KIND_ADD) begin
                        if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                            n_state = S_FIRE_RD;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end else if (i_kind == KIND_REMOVE) begin
                        n_state = S_REM_RD;
                    end else begin
                        n_state = S_FIRE_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == r_count) begin
                    n_pos = r_idx;
                    n_j = r_count;
                    n_state = S_INS_SHIFT;
                end else begin
                    ram_re = 1'b1;
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (ram_rdata.deadline <= r_dl) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_pos = r_idx;
                    n_j = r_count;
                    n_state = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                if (r_j == r_pos) begin
                    ram_we = 1'b1;
                    ram_wdata = '{deadline: r_dl, key: r_key, handler: r_tag};
                    n_count = r_count + 1'b1;
                    n_state = S_FIRE_RD;
                end else begin
                    ram_re = 1'b1;
                    ram_raddr = f_phys(r_head, r_j - 1'b1);
                    n_state = S_INS_MOVE;
                end
            end
            S_INS_MOVE: begin
                ram_we = 1'b1;
                n_j = r_j - 1'b1;
                n_state = S_INS_SHIFT;
            end
            S_REM_RD: begin
                if (r_idx == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state = S_FIRE_RD;
                end else begin
                    ram_re = 1'b1;
                    n_state = S_REM_CHK;
                end
            end
            S_REM_CHK: begin
                if (ram_rdata.key == r_key) begin
                    n_j = r_idx;
                    n_state = S_REM_SHIFT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_REM_RD;
                end
            end
            S_REM_SHIFT: begin
                if ((r_j + 1'b1) >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_FIRE_RD;
                end else begin
                    ram_re = 1'b1;
                    ram_raddr = f_phys(r_head, r_j + 1'b1);
                    n_state = S_REM_MOVE;
                end
            end
            S_REM_MOVE: begin
                ram_we = 1'b1;
                n_j = r_j + 1'b1;
                n_state = S_REM_SHIFT;
            end
            S_FIRE_RD: begin
                if (r_count == '0) begin
                    n_state = S_STATUS;
                end else begin
                    ram_re = 1'b1;
                    ram_raddr = r_head;
                    n_state = S_FIRE_CHK;
                end
            end
            S_FIRE_CHK: begin
                if ({1'b0, ram_rdata.deadline} <= r_limit) begin
                    // Pop the head once the output word is free
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_is_status = 1'b0;
                        n_last = 1'b0;
                        n_empty = 1'b0;
                        n_okey = ram_rdata.key;
                        n_otag = ram_rdata.handler;
                        n_ostat = ST_OK;
                        n_odl = '0;
                        n_head = ({1'b0, r_head} + 1'b1 == DEPTH_W) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                        n_state = S_FIRE_RD;
                    end
                end else begin
                    n_head_dl = ram_rdata.deadline;
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_is_status = 1'b1;
                    n_last = 1'b1;
                    n_empty = (r_count == '0);
                    n_okey = '0;
                    n_otag = '0;
                    n_ostat = r_status;
                    n_odl = (r_count == '0) ? '0 : r_head_dl;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head <= '0;
            r_res <= RES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head <= n_head;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_res <= i_cfg_data;
            end
        end
    end

    // Item fields, working indexes and output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dl <= add_sum[DL_W] ? {DL_W{1'b1}} : add_sum[DL_W-1:0];
            r_limit <= lim_sum;
            r_key <= i_key;
            r_tag <= i_handler_tag;
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_j <= n_j;
        r_head_dl <= n_head_dl;
        r_status <= n_status;
        r_is_status <= n_is_status;
        r_last <= n_last;
        r_empty <= n_empty;
        r_okey <= n_okey;
        r_otag <= n_otag;
        r_ostat <= n_ostat;
        r_odl <= n_odl;
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_status     = r_is_status;
    assign o_fired_key     = r_okey;
    assign o_fired_handler = r_otag;
    assign o_status        = r_ostat;
    assign o_queue_empty   = r_empty;
    assign o_next_deadline = r_odl;
    assign o_last          = r_last;

    `STEQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `STEQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `STEQ_ASSERT_NOW(a_shift_order, i_clk, i_rst_n, r_state == S_INS_SHIFT, r_j >= r_pos)
    `STEQ_ASSERT_NOW(a_insert_room, i_clk, i_rst_n, r_state == S_INS_SHIFT, r_count != FULL_CNT)
endmodule
`default_nettype wire
